// File: hdl/ahrpb_pkg.sv
// ----------------------------------------------------------------------------
// ahrpb_pkg
// Shared types, constants and helpers for the ASCII hex register frame
// builder: request and character payloads, frame descriptor, register indexes.
// ----------------------------------------------------------------------------
package ahrpb_pkg;

  // Configuration register indexes
  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] REG_WRITE_FUNC = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_READ_FUNC  = 2'd1;

  // Reset values of the function codes
  localparam logic [7:0] WRITE_FUNC_RESET = 8'h01;
  localparam logic [7:0] READ_FUNC_RESET  = 8'h02;

  // Request opcodes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Frame characters
  localparam logic [7:0] CHAR_COLON   = 8'h3A;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // Character position within a frame
  localparam int IDX_W = 5;
  localparam logic [IDX_W-1:0] WRITE_LAST_IDX = 5'd17;
  localparam logic [IDX_W-1:0] READ_LAST_IDX  = 5'd9;

  // Queue depth between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic        opcode;
    logic [7:0]  device_address;
    logic [7:0]  register_address;
    logic [31:0] write_value;
  } req_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last_character;
  } char_t;

  // Classified request, ready to serialize
  typedef struct packed {
    logic        is_write;
    logic [7:0]  dev;
    logic [7:0]  func;
    logic [7:0]  regaddr;
    logic [31:0] value;
    logic [7:0]  check;
  } desc_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Uppercase hex digit of one nibble
  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'h0, nib};
    end else begin
      c = 8'h37 + {4'h0, nib};
    end
    return c;
  endfunction

endpackage

// File: hdl/ascii_hex_register_packet_builder.sv
// ----------------------------------------------------------------------------
// ascii_hex_register_packet_builder
// Builds ASCII hex register request frames with a two's-complement checksum.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one register request
//   per transaction. Output channel (out_valid / out_stall / out_data) gives
//   one frame character per transaction; last_character marks the newline.
//   A write frame is 18 characters, a read frame 10.
//   Configuration channel (cfg_valid / cfg_ready / cfg_index / cfg_data)
//   sets the write (index 0) and read (index 1) function codes; cfg_ready is
//   always high. Write it only while no frame is in flight.
// Flow:
//   A request accepted into an idle block passes the front register, a queue
//   entry, the serializer and the output register in that order before
//   out_valid rises. One character leaves per cycle while out_stall is low,
//   and the next frame starts right after the newline. Up to three further
//   requests are absorbed while a frame streams out.
// Reset: rst is synchronous, active high; clears all control state and
//   restores function codes to 1 (write) and 2 (read).
// Stall: out_stall holds the current character; the serializer waits, the
//   queue fills and in_stall then rises.
// ----------------------------------------------------------------------------
module ascii_hex_register_packet_builder (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ahrpb_pkg::req_t                   in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output ahrpb_pkg::char_t                  out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ahrpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data
);
  import ahrpb_pkg::*;

  logic       push;
  desc_t      push_data;
  logic       pop;
  desc_t      head;
  q_status_t  q_status;

  assign cfg_ready = 1'b1;

  ahrpb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .push      (push),
    .push_data (push_data),
    .q_status  (q_status)
  );

  ahrpb_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_status  (q_status)
  );

  ahrpb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // Queue never overflows or underflows
  assert property (@(posedge clk) disable iff (rst) push |-> !q_status.full)
    else $error("queue push while full");
  assert property (@(posedge clk) disable iff (rst) pop |-> !q_status.empty)
    else $error("queue pop while empty");

  // Frame end marker only on the newline
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.last_character |-> out_data.character == CHAR_NEWLINE)
    else $error("frame end marker on a non-newline character");

  // Nothing leaves the block right after reset
  assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("output valid after reset");

endmodule

// File: hdl/ahrpb_front.sv
// ----------------------------------------------------------------------------
// ahrpb_front
// Accepts requests, holds the function code registers, picks the function
// code, computes the checksum and pushes one frame descriptor to the queue.
// ----------------------------------------------------------------------------
module ahrpb_front (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  ahrpb_pkg::req_t                   in_data,
  input  logic                              cfg_valid,
  input  logic [ahrpb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                        cfg_data,
  output logic                              push,
  output ahrpb_pkg::desc_t                  push_data,
  input  ahrpb_pkg::q_status_t              q_status
);
  import ahrpb_pkg::*;

  logic       [7:0] wr_code;
  logic       [7:0] rd_code;
  logic             stage_valid;
  desc_t            stage;
  desc_t            stage_next;
  logic       [7:0] sum;
  logic             in_accept;

  // Update function codes on configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_code <= WRITE_FUNC_RESET;
      rd_code <= READ_FUNC_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WRITE_FUNC) begin
        wr_code <= cfg_data;
      end else if (cfg_index == REG_READ_FUNC) begin
        rd_code <= cfg_data;
      end
    end
  end

  // Classify the request and form the checksum
  always_comb begin
    stage_next.is_write = (in_data.opcode == OP_WRITE);
    stage_next.dev      = in_data.device_address;
    stage_next.func     = stage_next.is_write ? wr_code : rd_code;
    stage_next.regaddr  = in_data.register_address;
    stage_next.value    = in_data.write_value;
    sum = stage_next.dev + stage_next.func + stage_next.regaddr;
    if (stage_next.is_write) begin
      sum = sum + in_data.write_value[7:0] + in_data.write_value[15:8]
                + in_data.write_value[23:16] + in_data.write_value[31:24];
    end
    stage_next.check = 8'h00 - sum;
  end

  // Hold a request until the queue has room
  assign push      = stage_valid && !q_status.full;
  assign push_data = stage;
  assign in_stall  = stage_valid && q_status.full;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_accept) begin
      stage_valid <= 1'b1;
    end else if (push) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage <= stage_next;
    end
  end

endmodule

// File: hdl/ahrpb_queue.sv
// ----------------------------------------------------------------------------
// ahrpb_queue
// Two-entry descriptor queue that decouples the front from the serializer.
// ----------------------------------------------------------------------------
module ahrpb_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  ahrpb_pkg::desc_t     push_data,
  input  logic                 pop,
  output ahrpb_pkg::desc_t     head,
  output ahrpb_pkg::q_status_t q_status
);
  import ahrpb_pkg::*;

  desc_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  count;

  assign q_status.full  = (count == QCNT_W'(QUEUE_DEPTH));
  assign q_status.empty = (count == '0);
  assign head           = entries[rd_ptr];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Store descriptors
  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

// File: hdl/ahrpb_back.sv
// ----------------------------------------------------------------------------
// ahrpb_back
// Serializer: walks one descriptor a character per cycle into an output
// register unless stalled, loading the next descriptor on the newline cycle.
// ----------------------------------------------------------------------------
module ahrpb_back (
  input  logic                 clk,
  input  logic                 rst,
  input  ahrpb_pkg::desc_t     head,
  input  ahrpb_pkg::q_status_t q_status,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ahrpb_pkg::char_t     out_data
);
  import ahrpb_pkg::*;

  desc_t             cur;
  logic              cur_valid;
  logic [IDX_W-1:0]  idx;
  logic              advance;
  logic              is_last;
  logic [3:0]        digit;
  logic [63:0]       nibbles;
  logic [3:0]        nib;
  char_t             next_char;

  assign advance = !out_valid || !out_stall;
  assign is_last = (idx == (cur.is_write ? WRITE_LAST_IDX : READ_LAST_IDX));
  assign pop     = !q_status.empty && (!cur_valid || (advance && is_last));

  // Pick the character at the current position
  always_comb begin
    digit = 4'(idx - 1'b1);
    if (cur.is_write) begin
      nibbles = {cur.dev, cur.func, cur.regaddr, cur.value, cur.check};
    end else begin
      nibbles = {cur.dev, cur.func, cur.regaddr, cur.check, 32'h0};
    end
    nib = nibbles[{~digit, 2'b00} +: 4];
    next_char.last_character = is_last;
    priority if (idx == '0) begin
      next_char.character = CHAR_COLON;
    end else if (is_last) begin
      next_char.character = CHAR_NEWLINE;
    end else begin
      next_char.character = hex_char(nib);
    end
  end

  // Step through the frame and load the next descriptor
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      if (advance) begin
        out_valid <= cur_valid;
      end
      if (pop) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (advance && cur_valid) begin
        if (is_last) begin
          cur_valid <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
    if (advance && cur_valid) begin
      out_data <= next_char;
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the ASCII hex register frame builder. Register
// requests go in over the input channel. A local frame predictor turns each
// accepted request into its expected character stream: colon, hex fields,
// LRC checksum and newline. Every character that comes out is compared with
// the oldest expected one. Function code registers are changed between
// phases while the block is idle. The phases cover a mix of source gaps and
// sink stalls.
// ----------------------------------------------------------------------------
module tb;
  import ahrpb_pkg::*;

  localparam int QUIET_LIMIT   = 2000;
  localparam int DRAIN_CYCLES  = 8;
  localparam int RESET_CYCLES  = 6;
  localparam int PHASE_ITEMS   = 50;
  localparam int REPORT_LIMIT  = 10;

  // Register indexes with no register behind them
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 2'd3;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  req_t                   in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  char_t                  out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [7:0]             cfg_data = '0;

  // Shadow copies of the function code registers
  logic [7:0] write_code = WRITE_FUNC_RESET;
  logic [7:0] read_code  = READ_FUNC_RESET;

  char_t pending_chars[$];

  int source_idle_pct = 0;
  int sink_stall_pct  = 0;
  int fail_count      = 0;
  int reads_sent      = 0;
  int writes_sent     = 0;
  int chars_checked   = 0;
  int cfg_writes      = 0;

  ascii_hex_register_packet_builder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #1 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Frame predictor
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] ascii_nibble(input logic [3:0] nib);
    if (nib < 4'd10) begin
      return 8'h30 + 8'(nib);
    end
    return 8'h41 + 8'(nib) - 8'd10;
  endfunction

  function automatic void expect_char(input logic [7:0] c, input logic last);
    char_t item;
    item.character      = c;
    item.last_character = last;
    pending_chars.push_back(item);
  endfunction

  function automatic void expect_hex_byte(input logic [7:0] b);
    expect_char(ascii_nibble(b[7:4]), 1'b0);
    expect_char(ascii_nibble(b[3:0]), 1'b0);
  endfunction

  function automatic void expect_frame(input req_t r);
    logic [7:0] func;
    logic [7:0] lrc_sum;
    func    = (r.opcode == OP_WRITE) ? write_code : read_code;
    lrc_sum = r.device_address + func + r.register_address;
    if (r.opcode == OP_WRITE) begin
      lrc_sum = lrc_sum + r.write_value[31:24] + r.write_value[23:16]
              + r.write_value[15:8] + r.write_value[7:0];
    end
    expect_char(CHAR_COLON, 1'b0);
    expect_hex_byte(r.device_address);
    expect_hex_byte(func);
    expect_hex_byte(r.register_address);
    if (r.opcode == OP_WRITE) begin
      expect_hex_byte(r.write_value[31:24]);
      expect_hex_byte(r.write_value[23:16]);
      expect_hex_byte(r.write_value[15:8]);
      expect_hex_byte(r.write_value[7:0]);
    end
    expect_hex_byte(8'h00 - lrc_sum);
    expect_char(CHAR_NEWLINE, 1'b1);
  endfunction

  // ---------------------------------------------------------------------------
  // Sink side: random stall and character check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_stall <= (sink_stall_pct != 0) && ($urandom_range(99) < sink_stall_pct);
  end

  always @(posedge clk) begin : check_chars
    char_t want;
    if (!rst && out_valid && !out_stall) begin
      chars_checked++;
      if (pending_chars.size() == 0) begin
        fail_count++;
        if (fail_count <= REPORT_LIMIT) begin
          $display("tb: unexpected character %02h last=%0b", out_data.character,
                   out_data.last_character);
        end
      end else begin
        want = pending_chars.pop_front();
        if (out_data.character !== want.character ||
            out_data.last_character !== want.last_character) begin
          fail_count++;
          if (fail_count <= REPORT_LIMIT) begin
            $display("tb: character mismatch: expected %02h last=%0b, got %02h last=%0b",
                     want.character, want.last_character, out_data.character,
                     out_data.last_character);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Watchdog: end the run after too long without any transaction
  // ---------------------------------------------------------------------------
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) ||
          (cfg_valid && cfg_ready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("tb: timeout after %0d quiet cycles", QUIET_LIMIT);
    $display("tb: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Shared drivers
  // ---------------------------------------------------------------------------
  // Send one request; hold it until the block takes it
  task automatic send_request(input req_t r);
    while (source_idle_pct != 0 && $urandom_range(99) < source_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do begin
      @(posedge clk);
    end while (in_stall);
    expect_frame(r);
    if (r.opcode == OP_WRITE) begin
      writes_sent++;
    end else begin
      reads_sent++;
    end
  endtask

  // Drop valid and wait until every expected character has come out
  task automatic drain;
    in_valid <= 1'b0;
    while (pending_chars.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    case (idx)
      REG_WRITE_FUNC: write_code = value;
      REG_READ_FUNC:  read_code  = value;
      default: ;
    endcase
    cfg_writes++;
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  function automatic req_t make_request(input logic op, input logic [7:0] dev,
                                        input logic [7:0] regaddr, input logic [31:0] value);
    req_t r;
    r.opcode           = op;
    r.device_address   = dev;
    r.register_address = regaddr;
    r.write_value      = value;
    return r;
  endfunction

  // Byte biased toward the extremes
  function automatic logic [7:0] pick_byte;
    case ($urandom_range(7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic req_t random_request;
    logic [31:0] value;
    case ($urandom_range(7))
      0:       value = 32'h0000_0000;
      1:       value = 32'hFFFF_FFFF;
      default: value = $urandom;
    endcase
    return make_request(1'($urandom_range(1)), pick_byte(), pick_byte(), value);
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Reset function codes, field extremes, every hex digit, zero and wrapped sums
  task automatic test_default_codes;
    send_request(make_request(OP_READ,  8'h00, 8'h00, 32'hFFFF_FFFF));
    send_request(make_request(OP_READ,  8'hFF, 8'hFF, 32'h0000_0000));
    send_request(make_request(OP_WRITE, 8'h00, 8'h00, 32'h0000_0000));
    send_request(make_request(OP_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_WRITE, 8'h12, 8'h34, 32'h89AB_CDEF));
    send_request(make_request(OP_WRITE, 8'hAB, 8'hCD, 32'h0123_4567));
    // Byte sum of exactly 0x100: checksum comes out as zero
    send_request(make_request(OP_WRITE, 8'hFF, 8'h00, 32'h0000_0000));
    send_request(make_request(OP_READ,  8'hFE, 8'h00, 32'h5A5A_5A5A));
    send_request(make_request(OP_READ,  8'h7F, 8'h80, 32'hDEAD_BEEF));
    drain();
  endtask

  // Both function code registers at their extremes; spare indexes do nothing
  task automatic test_function_codes;
    write_register(REG_WRITE_FUNC, 8'h00);
    write_register(REG_READ_FUNC,  8'hFF);
    write_register(REG_SPARE_LO,   8'hA5);
    write_register(REG_SPARE_HI,   8'h5A);
    send_request(make_request(OP_WRITE, 8'h00, 8'h00, 32'h0000_0000));
    send_request(make_request(OP_READ,  8'h00, 8'h00, 32'h0000_0000));
    send_request(make_request(OP_WRITE, 8'h55, 8'hAA, 32'hFFFF_FFFF));
    send_request(make_request(OP_READ,  8'h01, 8'h00, 32'h1234_5678));
    drain();
    write_register(REG_WRITE_FUNC, 8'hFF);
    write_register(REG_READ_FUNC,  8'h00);
    send_request(make_request(OP_WRITE, 8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_READ,  8'hFF, 8'hFF, 32'hFFFF_FFFF));
    send_request(make_request(OP_WRITE, 8'h01, 8'h00, 32'h0000_0000));
    send_request(make_request(OP_READ,  8'h00, 8'h01, 32'h0000_0000));
    drain();
  endtask

  // Random requests under one source/sink idle mix and one code setting
  task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [7:0] wcode, input logic [7:0] rcode);
    write_register(REG_WRITE_FUNC, wcode);
    write_register(REG_READ_FUNC,  rcode);
    write_register(1'b1 ? ($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI) : REG_SPARE_LO,
                   8'($urandom_range(255)));
    source_idle_pct = idle_pct;
    sink_stall_pct  = stall_pct;
    repeat (PHASE_ITEMS) begin
      send_request(random_request());
    end
    drain();
    source_idle_pct = 0;
    sink_stall_pct  = 0;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    test_default_codes();
    test_function_codes();
    test_random_phase(0,  0,  WRITE_FUNC_RESET, READ_FUNC_RESET);
    test_random_phase(69, 0,  8'h00, 8'hFF);
    test_random_phase(0,  69, 8'hFF, 8'h00);
    test_random_phase(17, 17, 8'($urandom_range(255)), 8'($urandom_range(255)));

    $display("tb: %0d requests (%0d write, %0d read), %0d characters checked",
             writes_sent + reads_sent, writes_sent, reads_sent, chars_checked);
    $display("tb: %0d register writes, phases with no gaps, source gaps, sink stalls, both",
             cfg_writes);
    if (fail_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: %0d failures", fail_count);
      $display("tb: errors");
    end
    $finish;
  end

endmodule
